@@ rtl/core/gtp_pkg.sv @@
// Shared types and constants for the GPU task partition calculator.
// Used by gpu_task_partition_calc.
`default_nettype none
package gtp_pkg;

   localparam int MAX_CORES   = 32;
   localparam int MAX_WARPS   = 32;
   localparam int MAX_THREADS = 32;

   localparam int TASK_W = 31;
   localparam int CFG_W  = 6;
   localparam int IDX_W  = 5;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORES   = 2'd0,
      CSR_WARPS   = 2'd1,
      CSR_THREADS = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   localparam logic [CFG_W-1:0] CORES_RESET   = 6'd1;
   localparam logic [CFG_W-1:0] WARPS_RESET   = 6'd4;
   localparam logic [CFG_W-1:0] THREADS_RESET = 6'd4;

   typedef struct packed {
      logic [TASK_W-1:0] task_total;
      logic [IDX_W-1:0]  core_index;
      logic [IDX_W-1:0]  warp_index;
      logic [IDX_W-1:0]  thread_index;
   } req_type;

   typedef struct packed {
      logic              core_takes_part;
      logic [CFG_W-1:0]  warps_to_spawn;
      logic              warp_phase_active;
      logic [TASK_W-1:0] first_task;
      logic [TASK_W-1:0] task_count;
      logic [TASK_W-1:0] leftover_mask;
      logic [TASK_W-1:0] leftover_base;
      logic [TASK_W-1:0] leftover_task;
      logic              leftover_valid;
   } rsp_type;

   // Clamp a register value into 1..hi; hi may reach 64.
   function automatic logic [CFG_W-1:0] sat_range(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W:0] hi);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = 6'd1;
      end else if ({1'b0, v} > hi) begin
         r = hi[CFG_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/gtp_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and hands on.
// Standalone; instantiated by gtp_div_chain.
`default_nettype none
module gtp_div_cell #(
   parameter int NW  = 31,
   parameter int DW  = 12,
   parameter int SW  = 8,
   parameter int BIT = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          prev_valid,
   input  wire logic [DW-1:0] prev_rem,
   input  wire logic [NW-1:0] prev_num,
   input  wire logic [NW-1:0] prev_quo,
   input  wire logic [DW-1:0] prev_den,
   input  wire logic [SW-1:0] prev_side,
   output logic               valid,
   output logic [DW-1:0]      rem,
   output logic [NW-1:0]      num,
   output logic [NW-1:0]      quo,
   output logic [DW-1:0]      den,
   output logic [SW-1:0]      side
);

   logic          valid_ff;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [NW-1:0] num_ff, quo_ff, quo_in;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial, diff;
   logic          ge;

   always_comb begin
      trial  = {prev_rem, prev_num[BIT]};
      diff   = trial - {1'b0, prev_den};
      ge     = trial >= {1'b0, prev_den};
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_in = prev_quo;
      quo_in[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         num_ff  <= prev_num;
         quo_ff  <= quo_in;
         den_ff  <= prev_den;
         side_ff <= prev_side;
      end
   end

   assign valid = valid_ff;
   assign rem   = rem_ff;
   assign num   = num_ff;
   assign quo   = quo_ff;
   assign den   = den_ff;
   assign side  = side_ff;

endmodule
`default_nettype wire

@@ rtl/core/gtp_div_chain.sv @@
// Row of NW division cells, one quotient bit per cell, MSB first.
// Depends on gtp_div_cell.
`default_nettype none
module gtp_div_chain #(
   parameter int NW = 31,
   parameter int DW = 12,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [NW-1:0]      out_quo,
   output logic [DW-1:0]      out_rem,
   output logic [SW-1:0]      out_side
);

   logic          valid_w [0:NW];
   logic [DW-1:0] rem_w   [0:NW];
   logic [NW-1:0] num_w   [0:NW];
   logic [NW-1:0] quo_w   [0:NW];
   logic [DW-1:0] den_w   [0:NW];
   logic [SW-1:0] side_w  [0:NW];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign num_w[0]   = in_num;
   assign quo_w[0]   = '0;
   assign den_w[0]   = in_den;
   assign side_w[0]  = in_side;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      gtp_div_cell #(
         .NW (NW),
         .DW (DW),
         .SW (SW),
         .BIT(NW - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_valid(valid_w[k]),
         .prev_rem  (rem_w[k]),
         .prev_num  (num_w[k]),
         .prev_quo  (quo_w[k]),
         .prev_den  (den_w[k]),
         .prev_side (side_w[k]),
         .valid     (valid_w[k+1]),
         .rem       (rem_w[k+1]),
         .num       (num_w[k+1]),
         .quo       (quo_w[k+1]),
         .den       (den_w[k+1]),
         .side      (side_w[k+1])
      );
   end

   assign out_valid = valid_w[NW];
   assign out_quo   = quo_w[NW];
   assign out_rem   = rem_w[NW];
   assign out_side  = side_w[NW];

endmodule
`default_nettype wire

@@ rtl/core/gpu_task_partition_calc.sv @@
// Top level of the GPU task partition calculator.
// Depends on gtp_pkg and gtp_div_chain.
//
//   port group  direction  beat
//   req_*       in         req_type: task total and core/warp/thread position
//   rsp_*       out        rsp_type: share, warp-phase and leftover results
//   csr_*       in         register write: index, 6-bit data
//
// One beat is taken per cycle while the pipe is not stalled; the path holds 4*31 division
// cells plus 7 registers, from the four chained 31-bit dividers, one bit per cell.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stalled result freezes the whole pipe; req_stall follows at once.
`default_nettype none
module gpu_task_partition_calc #(
   parameter int MAX_CORES   = gtp_pkg::MAX_CORES,
   parameter int MAX_WARPS   = gtp_pkg::MAX_WARPS,
   parameter int MAX_THREADS = gtp_pkg::MAX_THREADS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire gtp_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output gtp_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [gtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gtp_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int TW = gtp_pkg::TASK_W;
   localparam int CW = gtp_pkg::CFG_W;
   localparam int IW = gtp_pkg::IDX_W;
   localparam logic [CW:0] MAXC = (CW+1)'(MAX_CORES);
   localparam logic [CW:0] MAXW = (CW+1)'(MAX_WARPS);
   localparam logic [CW:0] MAXT = (CW+1)'(MAX_THREADS);
   localparam int SLOT_W = 2 * CW;

   typedef struct packed {
      logic [TW-1:0] total;
      logic [IW-1:0] core;
      logic [IW-1:0] warp;
      logic [IW-1:0] thr;
      logic          part;
      logic [CW-1:0] active;
   } s2_type;

   typedef struct packed {
      logic          part;
      logic          last;
      logic [TW-1:0] total;
      logic [TW-1:0] share;
      logic [TW-1:0] prod_last;
      logic [TW-1:0] base;
      logic [IW-1:0] warp;
      logic [IW-1:0] thr;
   } sb_type;

   typedef struct packed {
      logic          part;
      logic [IW-1:0] warp;
      logic [IW-1:0] thr;
      logic [TW-1:0] base;
      logic [TW-1:0] my_share;
   } s3_type;

   typedef struct packed {
      logic          part;
      logic [IW-1:0] warp;
      logic [IW-1:0] thr;
      logic [TW-1:0] base;
      logic [TW-1:0] my_share;
      logic [CW-1:0] left;
      logic [TW-1:0] rows;
   } s4_type;

   typedef struct packed {
      logic          part;
      logic [CW-1:0] spawn;
      logic          wact;
      logic          tact;
      logic [TW-1:0] fw;
      logic [IW-1:0] mn;
      logic [TW:0]   count;
      logic [TW-1:0] base;
      logic [TW-1:0] lbase;
      logic [CW-1:0] left;
      logic [IW-1:0] thr;
   } sd_type;

   typedef struct packed {
      logic          part;
      logic [CW-1:0] spawn;
      logic          wact;
      logic          tact;
      logic [TW-1:0] prior;
      logic [TW:0]   count;
      logic [TW-1:0] base;
      logic [TW-1:0] lbase;
      logic [CW-1:0] left;
      logic [IW-1:0] thr;
   } se_type;

   typedef struct packed {
      logic          part;
      logic [CW-1:0] spawn;
      logic          wact;
      logic          tact;
      logic [TW-1:0] bn;
      logic [TW-1:0] tc;
      logic [TW:0]   count;
      logic [TW-1:0] base;
      logic [TW-1:0] lbase;
      logic [CW-1:0] left;
      logic [IW-1:0] thr;
   } sf_type;

   // configuration registers
   logic [CW-1:0] cores_ff, warps_ff, threads_ff;
   logic [CW-1:0] nc, nw, nt;
   logic [SLOT_W-1:0] slots;

   always_ff @(posedge clock) begin
      if (reset) begin
         cores_ff   <= gtp_pkg::CORES_RESET;
         warps_ff   <= gtp_pkg::WARPS_RESET;
         threads_ff <= gtp_pkg::THREADS_RESET;
      end else if (csr_we) begin
         case (gtp_pkg::csr_index_type'(csr_index))
            gtp_pkg::CSR_CORES:   cores_ff   <= csr_wdata;
            gtp_pkg::CSR_WARPS:   warps_ff   <= csr_wdata;
            gtp_pkg::CSR_THREADS: threads_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nc    = gtp_pkg::sat_range(cores_ff, MAXC);
   assign nw    = gtp_pkg::sat_range(warps_ff, MAXW);
   assign nt    = gtp_pkg::sat_range(threads_ff, MAXT);
   assign slots = SLOT_W'(nw * nt);

   logic en;
   logic rsp_valid_ff;
   gtp_pkg::rsp_type rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // divider 1: active cores from total / slots
   logic             d1_valid;
   logic [TW-1:0]    d1_quo;
   logic [SLOT_W-1:0] d1_rem;
   logic [$bits(gtp_pkg::req_type)-1:0] d1_side;

   gtp_div_chain #(.NW(TW), .DW(SLOT_W), .SW($bits(gtp_pkg::req_type))) u_div_cores (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_num(req_data.task_total), .in_den(slots),
      .in_side(req_data),
      .out_valid(d1_valid), .out_quo(d1_quo), .out_rem(d1_rem), .out_side(d1_side)
   );

   logic   a_valid_ff;
   s2_type a_ff, a_in;
   gtp_pkg::req_type d1_req;
   logic [TW-1:0] act_raw;

   always_comb begin
      d1_req   = gtp_pkg::req_type'(d1_side);
      act_raw  = (d1_req.task_total > TW'(slots)) ? d1_quo : TW'(1);
      a_in.total  = d1_req.task_total;
      a_in.core   = d1_req.core_index;
      a_in.warp   = d1_req.warp_index;
      a_in.thr    = d1_req.thread_index;
      a_in.active = (act_raw > TW'(nc)) ? nc : act_raw[CW-1:0];
      a_in.part   = (CW'(d1_req.core_index) < a_in.active)
                    && ((CW+1)'(d1_req.core_index) < MAXC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
      end
   end

   // divider 2: share = total / active
   logic          d2_valid;
   logic [TW-1:0] d2_quo;
   logic [CW-1:0] d2_rem;
   logic [$bits(s2_type)-1:0] d2_side;

   gtp_div_chain #(.NW(TW), .DW(CW), .SW($bits(s2_type))) u_div_share (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(a_valid_ff), .in_num(a_ff.total), .in_den(a_ff.active),
      .in_side(a_ff),
      .out_valid(d2_valid), .out_quo(d2_quo), .out_rem(d2_rem), .out_side(d2_side)
   );

   logic   b_valid_ff;
   sb_type b_ff, b_in;
   s2_type d2_s;
   logic [TW+CW-1:0] prod_l, prod_c;

   always_comb begin
      d2_s      = s2_type'(d2_side);
      prod_l    = (d2_s.active - CW'(1)) * d2_quo;
      prod_c    = CW'(d2_s.core) * d2_quo;
      b_in.part      = d2_s.part;
      b_in.last      = CW'(d2_s.core) == (d2_s.active - CW'(1));
      b_in.total     = d2_s.total;
      b_in.share     = d2_quo;
      b_in.prod_last = prod_l[TW-1:0];
      b_in.base      = prod_c[TW-1:0];
      b_in.warp      = d2_s.warp;
      b_in.thr       = d2_s.thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff <= b_in;
      end
   end

   // last active core absorbs the remainder
   logic   c_valid_ff;
   s3_type c_ff, c_in;

   always_comb begin
      c_in.part     = b_ff.part;
      c_in.warp     = b_ff.warp;
      c_in.thr      = b_ff.thr;
      c_in.base     = b_ff.base;
      c_in.my_share = b_ff.last ? (b_ff.total - b_ff.prod_last) : b_ff.share;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   // divider 3: rows and leftover from my_share / threads
   logic          d3_valid;
   logic [TW-1:0] d3_quo;
   logic [CW-1:0] d3_rem;
   logic [$bits(s3_type)-1:0] d3_side;

   gtp_div_chain #(.NW(TW), .DW(CW), .SW($bits(s3_type))) u_div_rows (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c_valid_ff), .in_num(c_ff.my_share), .in_den(nt),
      .in_side(c_ff),
      .out_valid(d3_valid), .out_quo(d3_quo), .out_rem(d3_rem), .out_side(d3_side)
   );

   s3_type d3_s;
   s4_type d4_in_side;

   always_comb begin
      d3_s = s3_type'(d3_side);
      d4_in_side.part     = d3_s.part;
      d4_in_side.warp     = d3_s.warp;
      d4_in_side.thr      = d3_s.thr;
      d4_in_side.base     = d3_s.base;
      d4_in_side.my_share = d3_s.my_share;
      d4_in_side.left     = d3_rem;
      d4_in_side.rows     = d3_quo;
   end

   // divider 4: rows per warp and the warps that take one more
   logic          d4_valid;
   logic [TW-1:0] d4_quo;
   logic [CW-1:0] d4_rem;
   logic [$bits(s4_type)-1:0] d4_side;

   gtp_div_chain #(.NW(TW), .DW(CW), .SW($bits(s4_type))) u_div_warps (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d3_valid), .in_num(d3_quo), .in_den(nw),
      .in_side(d4_in_side),
      .out_valid(d4_valid), .out_quo(d4_quo), .out_rem(d4_rem), .out_side(d4_side)
   );

   logic   d_valid_ff;
   sd_type d_ff, d_in;
   s4_type d4_s;
   logic [TW-1:0] full;
   logic [CW-1:0] extra;
   logic [TW+IW-1:0] fw_prod;

   always_comb begin
      d4_s  = s4_type'(d4_side);
      full  = (d4_quo == '0) ? TW'(1) : d4_quo;
      extra = (d4_quo == '0) ? '0 : d4_rem;
      fw_prod = full * d4_s.warp;
      d_in.part  = d4_s.part;
      d_in.spawn = (d4_s.rows > TW'(nw)) ? nw : d4_s.rows[CW-1:0];
      d_in.wact  = (d4_s.rows != '0) && (CW'(d4_s.warp) < d_in.spawn);
      d_in.tact  = d_in.wact && (CW'(d4_s.thr) < nt);
      d_in.fw    = fw_prod[TW-1:0];
      d_in.mn    = (extra < CW'(d4_s.warp)) ? extra[IW-1:0] : d4_s.warp;
      d_in.count = {1'b0, full} + ((CW'(d4_s.warp) < extra) ? (TW+1)'(1) : '0);
      d_in.base  = d4_s.base;
      d_in.lbase = d4_s.base + d4_s.my_share - TW'(d4_s.left);
      d_in.left  = d4_s.left;
      d_in.thr   = d4_s.thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= d4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   // warps before this one, in rows
   logic   e_valid_ff;
   se_type e_ff, e_in;

   always_comb begin
      e_in.part   = d_ff.part;
      e_in.spawn  = d_ff.spawn;
      e_in.wact   = d_ff.wact;
      e_in.tact   = d_ff.tact;
      e_in.prior  = d_ff.fw + TW'(d_ff.mn);
      e_in.count  = d_ff.count;
      e_in.base   = d_ff.base;
      e_in.lbase  = d_ff.lbase;
      e_in.left   = d_ff.left;
      e_in.thr    = d_ff.thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   logic   f_valid_ff;
   sf_type f_ff, f_in;
   logic [TW+CW-1:0] bn_prod;
   logic [TW+IW:0]   tc_prod;

   always_comb begin
      bn_prod = e_ff.prior * nt;
      tc_prod = e_ff.count * e_ff.thr;
      f_in.part  = e_ff.part;
      f_in.spawn = e_ff.spawn;
      f_in.wact  = e_ff.wact;
      f_in.tact  = e_ff.tact;
      f_in.bn    = bn_prod[TW-1:0];
      f_in.tc    = tc_prod[TW-1:0];
      f_in.count = e_ff.count;
      f_in.base  = e_ff.base;
      f_in.lbase = e_ff.lbase;
      f_in.left  = e_ff.left;
      f_in.thr   = e_ff.thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= f_in;
      end
   end

   // output formatting; drop everything for a core that sits out
   logic [63:0] mask_wide;
   logic        has_left;

   always_comb begin
      mask_wide = (64'd1 << f_ff.left) - 64'd1;
      has_left  = f_ff.part && (f_ff.left != '0);
      rsp_in = '0;
      rsp_in.core_takes_part   = f_ff.part;
      rsp_in.warps_to_spawn    = f_ff.part ? f_ff.spawn : '0;
      rsp_in.warp_phase_active = f_ff.part && f_ff.wact;
      if (f_ff.part && f_ff.tact) begin
         rsp_in.first_task = f_ff.base + f_ff.bn + f_ff.tc;
         rsp_in.task_count = f_ff.count[TW-1:0];
      end
      if (has_left) begin
         rsp_in.leftover_mask  = mask_wide[TW-1:0];
         rsp_in.leftover_base  = f_ff.lbase;
         rsp_in.leftover_task  = f_ff.lbase + TW'(f_ff.thr);
         rsp_in.leftover_valid = CW'(f_ff.thr) < f_ff.left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
